// ===== rtl/tmu_pkg.sv =====
// tmu_pkg: operation codes and common types of the transform matrix unit.
// Depends on nothing; used by the core and by its port checker.
`default_nettype none

package tmu_pkg;

  localparam int WORD_W  = 32;
  localparam int NUM_ROW = 4;
  localparam int NUM_ELEM = 16;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic [1:0]               col_t;
  typedef logic [3:0]               elem_idx_t;

  // Operation codes carried in the kind field; codes 6 and 7 do nothing.
  typedef enum logic [2:0] {
    KIND_IDENTITY = 3'd0,
    KIND_LOAD     = 3'd1,
    KIND_MULT     = 3'd2,
    KIND_INVERSE  = 3'd3,
    KIND_QUAT     = 3'd4,
    KIND_READ     = 3'd5
  } kind_t;

endpackage : tmu_pkg

`default_nettype wire

// ===== rtl/transform_matrix_unit_core.sv =====
// transform_matrix_unit_core: 4x4 column-major Q format transform matrix with
// load, post-multiply, rigid inverse, quaternion rotation and column read-back.
// Depends on tmu_pkg for operation codes and types.
`default_nettype none

// Usage: the block keeps one column-major 4x4 matrix (element row r, column c
// at index c*4+r) in signed fixed point with FRAC_BITS fraction bits, reset to
// identity. Each input transfer carries an operation (in_kind), a column index
// and four values. Each operation completes as it leaves the input register,
// so one item per clock is sustained unless a read waits there, and a
// following item always sees the matrix left by the one before it. The cycle
// is set by sixteen 32x32 multiplier lanes feeding four saturating 4-term dot
// products (shared with the nine quaternion products) and the matrix register.
// Only a read produces an output transfer; its result is loaded from the
// matrix into the output register as the read leaves the input register, and
// transfers out from there. A read waits in
// the input register only while the output register holds an unclaimed result
// that out_stall keeps; every other operation never stalls the input. A
// multiply stores column c of the product in a pending buffer and commits the
// whole buffer to the matrix when column 3 arrives; columns not sent since
// reset commit as zero, or as their older product. Products truncate toward
// zero, sums saturate to 32 bits. No clearing pass follows reset.
module transform_matrix_unit_core #(
  parameter int FRAC_BITS = 16
) (
  input  wire         clk,
  input  wire         rst_n,
  // input channel
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [2:0]  in_kind,
  input  wire  [1:0]  in_column,
  input  wire  signed [31:0] in_value_0,
  input  wire  signed [31:0] in_value_1,
  input  wire  signed [31:0] in_value_2,
  input  wire  signed [31:0] in_value_3,
  // result channel
  output logic        out_valid,
  input  wire         out_stall,
  output logic [1:0]  out_column,
  output logic signed [31:0] out_0,
  output logic signed [31:0] out_1,
  output logic signed [31:0] out_2,
  output logic signed [31:0] out_3
);

  localparam logic signed [31:0] ONE      = 32'sd1 <<< FRAC_BITS;
  localparam logic signed [63:0] ROUND_IN = (64'sd1 <<< FRAC_BITS) - 64'sd1;
  localparam logic signed [65:0] MAX_W    = 66'sd2147483647;
  localparam logic signed [65:0] MIN_W    = -66'sd2147483648;

  // Saturate a wide sum to the signed 32-bit range.
  function automatic tmu_pkg::word_t sat32(input logic signed [65:0] v);
    tmu_pkg::word_t res;
    if (v > MAX_W)      res = 32'sh7FFF_FFFF;
    else if (v < MIN_W) res = 32'sh8000_0000;
    else                res = v[31:0];
    return res;
  endfunction

  function automatic tmu_pkg::word_t add_sat(input tmu_pkg::word_t a, input tmu_pkg::word_t b);
    logic signed [65:0] s;
    s = {{34{a[31]}}, a} + {{34{b[31]}}, b};
    return sat32(s);
  endfunction

  function automatic tmu_pkg::word_t sub_sat(input tmu_pkg::word_t a, input tmu_pkg::word_t b);
    logic signed [65:0] s;
    s = {{34{a[31]}}, a} - {{34{b[31]}}, b};
    return sat32(s);
  endfunction

  // Exact product scaled down by FRAC_BITS, truncated toward zero.
  function automatic logic signed [63:0] mul_shift(input tmu_pkg::word_t a,
                                                   input tmu_pkg::word_t b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b);
    if (p[63]) p = p + ROUND_IN;
    return p >>> FRAC_BITS;
  endfunction

  // ---------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------
  logic                in_vld_r,  in_vld_nxt;
  logic [2:0]          in_kind_r;
  tmu_pkg::col_t       in_col_r;
  tmu_pkg::word_t      in_val_r   [tmu_pkg::NUM_ROW];

  tmu_pkg::word_t      mat_r      [tmu_pkg::NUM_ELEM];
  tmu_pkg::word_t      mat_nxt    [tmu_pkg::NUM_ELEM];
  tmu_pkg::word_t      pend_r     [tmu_pkg::NUM_ELEM];
  tmu_pkg::word_t      pend_nxt   [tmu_pkg::NUM_ELEM];

  logic                out_vld_r, out_vld_nxt;
  tmu_pkg::col_t       out_col_r;
  tmu_pkg::word_t      out_val_r  [tmu_pkg::NUM_ROW];

  // ---------------------------------------------------------------------
  // Handshake control
  // ---------------------------------------------------------------------
  logic out_free;
  logic is_read;
  logic fire;
  logic in_xfer;

  // Output register can take a result when empty or being drained now.
  assign out_free = !out_vld_r || !out_stall;
  assign is_read  = (in_kind_r == tmu_pkg::KIND_READ);
  // Every operation but a blocked read completes this cycle.
  assign fire     = in_vld_r && (!is_read || out_free);
  assign in_stall = in_vld_r && !fire;
  assign in_xfer  = in_valid && !in_stall;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_xfer)   in_vld_nxt = 1'b1;
    else if (fire) in_vld_nxt = 1'b0;
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (fire && is_read)       out_vld_nxt = 1'b1;
    else if (out_vld_r && !out_stall) out_vld_nxt = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Multiplier lanes: matrix-times-column, or the quaternion products
  // ---------------------------------------------------------------------
  tmu_pkg::word_t      x2, y2, z2;
  tmu_pkg::word_t      op_a   [tmu_pkg::NUM_ELEM];
  tmu_pkg::word_t      op_b   [tmu_pkg::NUM_ELEM];
  logic signed [63:0]  prod   [tmu_pkg::NUM_ELEM];
  tmu_pkg::word_t      dot    [tmu_pkg::NUM_ROW];
  tmu_pkg::word_t      qp     [9];
  logic signed [65:0]  acc;

  always_comb begin
    x2 = add_sat(in_val_r[0], in_val_r[0]);
    y2 = add_sat(in_val_r[1], in_val_r[1]);
    z2 = add_sat(in_val_r[2], in_val_r[2]);
    for (int i = 0; i < tmu_pkg::NUM_ELEM; i++) begin
      op_a[i] = '0;
      op_b[i] = '0;
    end
    if (in_kind_r == tmu_pkg::KIND_QUAT) begin
      // xx xy xz yy yz zz wx wy wz
      op_a[0] = in_val_r[0]; op_b[0] = x2;
      op_a[1] = in_val_r[0]; op_b[1] = y2;
      op_a[2] = in_val_r[0]; op_b[2] = z2;
      op_a[3] = in_val_r[1]; op_b[3] = y2;
      op_a[4] = in_val_r[1]; op_b[4] = z2;
      op_a[5] = in_val_r[2]; op_b[5] = z2;
      op_a[6] = in_val_r[3]; op_b[6] = x2;
      op_a[7] = in_val_r[3]; op_b[7] = y2;
      op_a[8] = in_val_r[3]; op_b[8] = z2;
    end else begin
      // lane r*4+k: row r of the matrix against input row k
      for (int r = 0; r < tmu_pkg::NUM_ROW; r++) begin
        for (int k = 0; k < tmu_pkg::NUM_ROW; k++) begin
          op_a[r*4+k] = mat_r[k*4+r];
          op_b[r*4+k] = in_val_r[k];
        end
      end
    end
    for (int i = 0; i < tmu_pkg::NUM_ELEM; i++) begin
      prod[i] = mul_shift(op_a[i], op_b[i]);
    end
    for (int r = 0; r < tmu_pkg::NUM_ROW; r++) begin
      acc = '0;
      for (int k = 0; k < tmu_pkg::NUM_ROW; k++) begin
        acc = acc + {{2{prod[r*4+k][63]}}, prod[r*4+k]};
      end
      dot[r] = sat32(acc);
    end
    for (int i = 0; i < 9; i++) begin
      qp[i] = sat32({{2{prod[i][63]}}, prod[i]});
    end
  end

  // ---------------------------------------------------------------------
  // Matrix and pending product update
  // ---------------------------------------------------------------------
  always_comb begin
    for (int i = 0; i < tmu_pkg::NUM_ELEM; i++) begin
      mat_nxt[i]  = mat_r[i];
      pend_nxt[i] = pend_r[i];
    end
    if (fire) begin
      case (in_kind_r)
        tmu_pkg::KIND_IDENTITY: begin
          for (int i = 0; i < tmu_pkg::NUM_ELEM; i++) begin
            mat_nxt[i] = (i % 5 == 0) ? ONE : '0;
          end
        end
        tmu_pkg::KIND_LOAD: begin
          for (int r = 0; r < tmu_pkg::NUM_ROW; r++) begin
            mat_nxt[{in_col_r, 2'(r)}] = in_val_r[r];
          end
        end
        tmu_pkg::KIND_MULT: begin
          for (int r = 0; r < tmu_pkg::NUM_ROW; r++) begin
            pend_nxt[{in_col_r, 2'(r)}] = dot[r];
          end
          // Column 3 commits the whole pending product.
          if (in_col_r == 2'd3) begin
            for (int i = 0; i < tmu_pkg::NUM_ELEM; i++) begin
              mat_nxt[i] = pend_nxt[i];
            end
          end
        end
        tmu_pkg::KIND_INVERSE: begin
          for (int c = 0; c < 3; c++) begin
            for (int r = 0; r < 3; r++) begin
              mat_nxt[c*4+r] = mat_r[r*4+c];
            end
          end
          for (int i = 12; i < 15; i++) begin
            mat_nxt[i] = sub_sat('0, mat_r[i]);
          end
        end
        tmu_pkg::KIND_QUAT: begin
          for (int i = 0; i < tmu_pkg::NUM_ELEM; i++) begin
            mat_nxt[i] = '0;
          end
          mat_nxt[0]  = sub_sat(ONE, add_sat(qp[3], qp[5]));
          mat_nxt[1]  = sub_sat(qp[1], qp[8]);
          mat_nxt[2]  = add_sat(qp[2], qp[7]);
          mat_nxt[4]  = add_sat(qp[1], qp[8]);
          mat_nxt[5]  = sub_sat(ONE, add_sat(qp[0], qp[5]));
          mat_nxt[6]  = sub_sat(qp[4], qp[6]);
          mat_nxt[8]  = sub_sat(qp[2], qp[7]);
          mat_nxt[9]  = add_sat(qp[4], qp[6]);
          mat_nxt[10] = sub_sat(ONE, add_sat(qp[0], qp[3]));
          mat_nxt[15] = ONE;
        end
        default: begin
          // read leaves the matrix alone; unused codes are dropped
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      for (int i = 0; i < tmu_pkg::NUM_ELEM; i++) begin
        mat_r[i]  <= (i % 5 == 0) ? ONE : '0;
        pend_r[i] <= '0;
      end
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
      for (int i = 0; i < tmu_pkg::NUM_ELEM; i++) begin
        mat_r[i]  <= mat_nxt[i];
        pend_r[i] <= pend_nxt[i];
      end
    end
  end

  // Payload registers: input on transfer, result when a read fires; else hold.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_kind_r   <= in_kind;
      in_col_r    <= in_column;
      in_val_r[0] <= in_value_0;
      in_val_r[1] <= in_value_1;
      in_val_r[2] <= in_value_2;
      in_val_r[3] <= in_value_3;
    end
    if (fire && is_read) begin
      out_col_r <= in_col_r;
      for (int r = 0; r < tmu_pkg::NUM_ROW; r++) begin
        out_val_r[r] <= mat_r[{in_col_r, 2'(r)}];
      end
    end
  end

  assign out_valid  = out_vld_r;
  assign out_column = out_col_r;
  assign out_0      = out_val_r[0];
  assign out_1      = out_val_r[1];
  assign out_2      = out_val_r[2];
  assign out_3      = out_val_r[3];

endmodule : transform_matrix_unit_core

`default_nettype wire

// ===== rtl/tmu_checker.sv =====
// tmu_checker: port-level assertions for transform_matrix_unit_core,
// bound to every instance of the core. Depends on tmu_pkg for kind codes.
`default_nettype none

module tmu_checker (
  input wire               clk,
  input wire               rst_n,
  input wire               in_valid,
  input wire               in_stall,
  input wire  [2:0]        in_kind,
  input wire  [1:0]        in_column,
  input wire               out_valid,
  input wire               out_stall,
  input wire  [1:0]        out_column,
  input wire  signed [31:0] out_0,
  input wire  signed [31:0] out_1,
  input wire  signed [31:0] out_2,
  input wire  signed [31:0] out_3
);

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_column) && $stable(out_0) &&
      $stable(out_1) && $stable(out_2) && $stable(out_3))
    else $error("stalled result payload changed");

  // Input backpressure only comes from a blocked result register.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled result");

  // A new result follows a read transfer via both registers, same column.
  a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2) &&
      $past(in_kind, 2) == tmu_pkg::KIND_READ && out_column == $past(in_column, 2))
    else $error("result without a matching read transfer");

endmodule : tmu_checker

bind transform_matrix_unit_core tmu_checker u_tmu_checker (.*);

`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking bench for transform_matrix_unit_core: directed table, then random traffic
// over three idle/stall mixes; read-backs match a local predictor or a typed table answer.
// Depends on tmu_pkg (operation codes, col_t) and the core RTL only.
module testbench;
  import tmu_pkg::*;

  localparam int FRAC         = 16;
  localparam int ONE          = 1 << FRAC;
  localparam int WMAX         = 32'sh7fff_ffff;
  localparam int WMIN         = 32'sh8000_0000;
  localparam int N_DIRECTED   = 25;
  localparam int QUIET_LIMIT  = 4000;
  localparam int TAIL_CYCLES  = 6;
  // Spare operation codes: the core must ignore them.
  localparam logic [2:0] KIND_SPARE_6 = 3'd6;
  localparam logic [2:0] KIND_SPARE_7 = 3'd7;

  // One input item; 'typed' marks a read whose answer is written into the table.
  typedef struct packed {
    logic [2:0]       kind;
    col_t             col;
    logic [3:0][31:0] val;
    logic             typed;
    logic [3:0][31:0] want;
  } stim_t;

  typedef struct packed {
    col_t             col;
    logic [3:0][31:0] row;
  } column_read_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [2:0] in_kind;
  logic [1:0] in_column;
  logic signed [31:0] in_value_0, in_value_1, in_value_2, in_value_3;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_column;
  logic signed [31:0] out_0, out_1, out_2, out_3;

  stim_t        cur_item;
  stim_t        directed_tbl [N_DIRECTED];
  column_read_t read_backs_q [$];
  column_read_t seen_rd, want_rd, pred_rd;
  logic         pred_is_read;
  int           mismatches = 0;
  int           in_idle_pct = 0;
  int           out_stall_pct = 0;

  // Predictor state: the matrix and the pending product buffer.
  int mat_now   [16];
  int pend_prod [16];

  transform_matrix_unit_core #(.FRAC_BITS(FRAC)) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_kind    (in_kind),
    .in_column  (in_column),
    .in_value_0 (in_value_0),
    .in_value_1 (in_value_1),
    .in_value_2 (in_value_2),
    .in_value_3 (in_value_3),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_column (out_column),
    .out_0      (out_0),
    .out_1      (out_1),
    .out_2      (out_2),
    .out_3      (out_3)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Fixed-point helpers of the predictor
  // ---------------------------------------------------------------------------
  function automatic int clamp32(input longint v);
    if (v > longint'(WMAX)) return WMAX;
    if (v < longint'(WMIN)) return WMIN;
    return int'(v);
  endfunction

  // Exact product, then shift out the fraction rounding toward zero.
  function automatic longint fx_prod(input int a, input int b);
    return (longint'(a) * longint'(b)) / (longint'(1) << FRAC);
  endfunction

  function automatic int fx_add(input int a, input int b);
    return clamp32(longint'(a) + longint'(b));
  endfunction

  function automatic int fx_sub(input int a, input int b);
    return clamp32(longint'(a) - longint'(b));
  endfunction

  // Advance the predicted matrix by one accepted item; return the read-back if any.
  task automatic apply_matrix_op(input stim_t s, output logic is_read,
                                 output column_read_t rd);
    int v [4];
    int prev [16];
    int x2, y2, z2, xx, xy, xz, yy, yz, zz, wx, wy, wz;
    longint acc;
    int base;
    for (int i = 0; i < 4; i++) v[i] = int'(s.val[i]);
    base = int'(s.col) * 4;
    is_read = 1'b0;
    rd = '0;
    case (s.kind)
      KIND_IDENTITY: begin
        for (int i = 0; i < 16; i++) mat_now[i] = (i % 5 == 0) ? ONE : 0;
      end
      KIND_LOAD: begin
        for (int r = 0; r < 4; r++) mat_now[base + r] = v[r];
      end
      KIND_MULT: begin
        // Each dot product sums the four truncated products exactly, saturating once.
        for (int r = 0; r < 4; r++) begin
          acc = 0;
          for (int k = 0; k < 4; k++) acc += fx_prod(mat_now[k * 4 + r], v[k]);
          pend_prod[base + r] = clamp32(acc);
        end
        if (s.col == 2'd3) mat_now = pend_prod;
      end
      KIND_INVERSE: begin
        // Transpose the rotation block, negate the translation, keep row 3.
        prev = mat_now;
        for (int c = 0; c < 3; c++)
          for (int r = 0; r < 3; r++) mat_now[c * 4 + r] = prev[r * 4 + c];
        for (int i = 12; i < 15; i++) mat_now[i] = fx_sub(0, mat_now[i]);
      end
      KIND_QUAT: begin
        x2 = fx_add(v[0], v[0]);
        y2 = fx_add(v[1], v[1]);
        z2 = fx_add(v[2], v[2]);
        xx = clamp32(fx_prod(v[0], x2));
        xy = clamp32(fx_prod(v[0], y2));
        xz = clamp32(fx_prod(v[0], z2));
        yy = clamp32(fx_prod(v[1], y2));
        yz = clamp32(fx_prod(v[1], z2));
        zz = clamp32(fx_prod(v[2], z2));
        wx = clamp32(fx_prod(v[3], x2));
        wy = clamp32(fx_prod(v[3], y2));
        wz = clamp32(fx_prod(v[3], z2));
        for (int i = 0; i < 16; i++) mat_now[i] = 0;
        mat_now[0]  = fx_sub(ONE, fx_add(yy, zz));
        mat_now[1]  = fx_sub(xy, wz);
        mat_now[2]  = fx_add(xz, wy);
        mat_now[4]  = fx_add(xy, wz);
        mat_now[5]  = fx_sub(ONE, fx_add(xx, zz));
        mat_now[6]  = fx_sub(yz, wx);
        mat_now[8]  = fx_sub(xz, wy);
        mat_now[9]  = fx_add(yz, wx);
        mat_now[10] = fx_sub(ONE, fx_add(xx, yy));
        mat_now[15] = ONE;
      end
      KIND_READ: begin
        is_read = 1'b1;
        rd.col = s.col;
        for (int r = 0; r < 4; r++) rd.row[r] = mat_now[base + r];
      end
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------------
  function automatic stim_t mk_op(input logic [2:0] k, input col_t c,
                                  input int v0, input int v1, input int v2, input int v3);
    stim_t s;
    s = '0;
    s.kind = k;
    s.col = c;
    s.val = {v3, v2, v1, v0};
    return s;
  endfunction

  // Read whose answer is plain from the operations before it.
  function automatic stim_t mk_chk(input col_t c,
                                   input int w0, input int w1, input int w2, input int w3);
    stim_t s;
    s = mk_op(KIND_READ, c, 0, 0, 0, 0);
    s.typed = 1'b1;
    s.want = {w3, w2, w1, w0};
    return s;
  endfunction

  // Mostly moderate values (within +-4.0), sometimes extremes or any 32-bit word.
  function automatic int rand_word();
    case ($urandom_range(7))
      0: return int'($urandom());
      1: begin
        case ($urandom_range(3))
          0: return WMAX;
          1: return WMIN;
          2: return -1;
          default: return 0;
        endcase
      end
      default: return int'($urandom_range(0, 8 * ONE)) - 4 * ONE;
    endcase
  endfunction

  // Quaternion components near the unit range, with the odd wild one.
  function automatic int quat_word();
    if ($urandom_range(9) == 0) return rand_word();
    return int'($urandom_range(0, 2 * ONE)) - ONE;
  endfunction

  function automatic col_t rand_col();
    return col_t'($urandom_range(3));
  endfunction

  // Present one item and hold it until the core takes the transfer.
  task automatic send_item(input stim_t s);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_kind    <= s.kind;
    in_column  <= s.col;
    in_value_0 <= s.val[0];
    in_value_1 <= s.val[1];
    in_value_2 <= s.val[2];
    in_value_3 <= s.val[3];
    cur_item   <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Random traffic: mostly full multiply passes over columns 0..3 with random
  // content, mixed with reads, loads and matrix rebuilds; a few passes skip a
  // column or get a read wedged in, and spare codes add noise.
  task automatic run_random(input int n_items);
    int done;
    int pick;
    done = 0;
    while (done < n_items) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        for (int c = 0; c < 4; c++) begin
          if ($urandom_range(19) != 0) begin
            send_item(mk_op(KIND_MULT, col_t'(c), rand_word(), rand_word(),
                            rand_word(), rand_word()));
            done++;
          end
          if ($urandom_range(11) == 0) begin
            send_item(mk_op(KIND_READ, rand_col(), rand_word(), rand_word(),
                            rand_word(), rand_word()));
            done++;
          end
        end
      end else if (pick < 62) begin
        send_item(mk_op(KIND_READ, rand_col(), rand_word(), rand_word(),
                        rand_word(), rand_word()));
        done++;
      end else if (pick < 74) begin
        send_item(mk_op(KIND_LOAD, rand_col(), rand_word(), rand_word(),
                        rand_word(), rand_word()));
        done++;
      end else if (pick < 79) begin
        send_item(mk_op(KIND_IDENTITY, rand_col(), rand_word(), rand_word(),
                        rand_word(), rand_word()));
        done++;
      end else if (pick < 85) begin
        send_item(mk_op(KIND_INVERSE, rand_col(), rand_word(), rand_word(),
                        rand_word(), rand_word()));
        done++;
      end else if (pick < 94) begin
        send_item(mk_op(KIND_QUAT, rand_col(), quat_word(), quat_word(),
                        quat_word(), quat_word()));
        done++;
      end else begin
        // Ignored by the core: do not count toward the item budget.
        send_item(mk_op($urandom_range(1) ? KIND_SPARE_7 : KIND_SPARE_6, rand_col(),
                        rand_word(), rand_word(), rand_word(), rand_word()));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver back-pressure
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < out_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Scoreboard: check the result transfer first, then predict from the input
  // transfer of the same edge, so the order within the step never matters.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen_rd.col = out_column;
      seen_rd.row = {out_3, out_2, out_1, out_0};
      if (read_backs_q.size() == 0) begin
        $display("%0t: read-back with none expected: column %0d got %h", $time,
                 seen_rd.col, seen_rd.row);
        mismatches++;
      end else begin
        want_rd = read_backs_q.pop_front();
        if (seen_rd.col !== want_rd.col) begin
          $display("%0t: out_column expected %0d got %0d", $time, want_rd.col, seen_rd.col);
          mismatches++;
        end
        for (int r = 0; r < 4; r++) begin
          if (seen_rd.row[r] !== want_rd.row[r]) begin
            $display("%0t: column %0d out_%0d expected %h got %h", $time, want_rd.col, r,
                     want_rd.row[r], seen_rd.row[r]);
            mismatches++;
          end
        end
      end
    end
    if (rst_n && in_valid && !in_stall) begin
      apply_matrix_op(cur_item, pred_is_read, pred_rd);
      if (pred_is_read) begin
        // Table rows with a typed answer override the predicted one.
        if (cur_item.typed) pred_rd.row = cur_item.want;
        read_backs_q.push_back(pred_rd);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: end the run after too many cycles without any transfer.
  // ---------------------------------------------------------------------------
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("[transform_matrix_unit_core] ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_kind    = '0;
    in_column  = '0;
    in_value_0 = '0;
    in_value_1 = '0;
    in_value_2 = '0;
    in_value_3 = '0;
    cur_item   = '0;
    // Predictor reset: identity matrix, empty product buffer.
    for (int i = 0; i < 16; i++) begin
      mat_now[i]   = (i % 5 == 0) ? ONE : 0;
      pend_prod[i] = 0;
    end

    directed_tbl = '{
      // Identity after reset.
      mk_chk(2'd0, ONE, 0, 0, 0),
      mk_chk(2'd3, 0, 0, 0, ONE),
      // Load the field extremes and read them straight back.
      mk_op(KIND_LOAD, 2'd1, WMIN, WMAX, 0, -1),
      mk_chk(2'd1, WMIN, WMAX, 0, -1),
      // Saturating dot products; columns 1 and 2 never sent commit as zero.
      mk_op(KIND_LOAD, 2'd0, WMAX, WMAX, WMAX, WMAX),
      mk_op(KIND_MULT, 2'd0, WMAX, WMAX, WMAX, WMAX),
      mk_op(KIND_MULT, 2'd3, WMIN, -ONE, ONE, WMIN),
      mk_op(KIND_READ, 2'd0, 0, 0, 0, 0),
      mk_chk(2'd1, 0, 0, 0, 0),
      // Identity ignores its values; rigid inverse negates the most negative
      // translation to the most positive value.
      mk_op(KIND_IDENTITY, 2'd3, -1, -1, -1, -1),
      mk_op(KIND_LOAD, 2'd3, WMIN, 5 * ONE, -7 * ONE, ONE),
      mk_op(KIND_INVERSE, 2'd0, 0, 0, 0, 0),
      mk_chk(2'd3, WMAX, -5 * ONE, 7 * ONE, ONE),
      // Off-diagonal rotation terms must move under the transpose.
      mk_op(KIND_LOAD, 2'd1, 2 * ONE, 3 * ONE, -ONE, 0),
      mk_op(KIND_INVERSE, 2'd2, 0, 0, 0, 0),
      mk_op(KIND_READ, 2'd0, 0, 0, 0, 0),
      // Quaternion with extreme components: doubled terms saturate.
      mk_op(KIND_QUAT, 2'd1, WMAX, WMIN, ONE, -1),
      mk_op(KIND_READ, 2'd2, 0, 0, 0, 0),
      mk_chk(2'd3, 0, 0, 0, ONE),
      // Matrix rewritten between columns of one product.
      mk_op(KIND_MULT, 2'd0, ONE, 2 * ONE, 0, 0),
      mk_op(KIND_LOAD, 2'd2, -ONE, ONE, -ONE, ONE),
      mk_op(KIND_MULT, 2'd3, 0, 0, ONE, ONE),
      // Spare codes change nothing.
      mk_op(KIND_SPARE_6, 2'd2, WMAX, WMIN, -1, ONE),
      mk_op(KIND_SPARE_7, 2'd1, -1, 0, WMIN, WMAX),
      mk_op(KIND_READ, 2'd0, -1, -1, -1, -1)
    };

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Phase one: sender idles lightly, receiver stalls hard.
    in_idle_pct   = 28;
    out_stall_pct = 75;
    for (int i = 0; i < N_DIRECTED; i++) send_item(directed_tbl[i]);
    run_random(140);

    // Phase two: the other way round.
    in_idle_pct   = 75;
    out_stall_pct = 28;
    run_random(140);

    // Phase three: back-to-back transfers on both sides.
    in_idle_pct   = 0;
    out_stall_pct = 0;
    run_random(145);

    in_valid <= 1'b0;
    // Drain every pending read-back, then give the core its latency.
    while (read_backs_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("[transform_matrix_unit_core] OK");
    end else begin
      $display("[transform_matrix_unit_core] ERROR");
    end
    $finish;
  end

endmodule

// ===== transform_matrix_unit_core.f =====
rtl/tmu_pkg.sv
rtl/transform_matrix_unit_core.sv
rtl/tmu_checker.sv
bench/testbench.sv
